// File: design/pcv_pkg.sv
// Shared types and constants for the packet checksum verifier.
`timescale 1ns / 1ps

package pcv_pkg;

    // Configuration register reset values
    localparam logic [15:0] ADD_OFFSET_RESET = 16'd10000;
    localparam logic [15:0] XOR_MASK_RESET   = 16'h5aa5;

    // Register indexes (word address bit 2)
    localparam logic REG_ADD_OFFSET = 1'b0;
    localparam logic REG_XOR_MASK   = 1'b1;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // One received frame byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } pcv_in_t;

    // One verification result
    typedef struct packed {
        logic        sum_ok;
        logic [7:0]  payload_length;
        logic [15:0] computed_sum;
        logic [15:0] stored_sum;
    } pcv_out_t;

    // Live configuration seen by the parser
    typedef struct packed {
        logic [15:0] add_offset;
        logic [15:0] xor_mask;
    } pcv_cfg_t;

    // Frame parser phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HIGH = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } pcv_phase_t;

endpackage

// File: design/pcv_cfg_regs.sv
// APB configuration registers for the packet checksum verifier.
`timescale 1ns / 1ps

module pcv_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pcv_pkg::ADDR_W-1:0]       paddr,
    input  logic [pcv_pkg::DATA_W-1:0]       pwdata,
    output logic [pcv_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    output pcv_pkg::pcv_cfg_t                cfg
);

    logic [15:0] add_offset_reg;
    logic [15:0] xor_mask_reg;
    logic        wr_en;
    logic [15:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_offset_reg <= pcv_pkg::ADD_OFFSET_RESET;
            xor_mask_reg   <= pcv_pkg::XOR_MASK_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                pcv_pkg::REG_ADD_OFFSET: add_offset_reg <= pwdata[15:0];
                pcv_pkg::REG_XOR_MASK:   xor_mask_reg   <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pcv_pkg::REG_ADD_OFFSET: rd_val = add_offset_reg;
            pcv_pkg::REG_XOR_MASK:   rd_val = xor_mask_reg;
            default:                 rd_val = 16'd0;
        endcase
    end

    assign prdata         = {16'd0, rd_val};
    assign cfg.add_offset = add_offset_reg;
    assign cfg.xor_mask   = xor_mask_reg;

endmodule

// File: design/pcv_frame_parser.sv
// Header parser and running checksum for one frame byte per step.
`timescale 1ns / 1ps

module pcv_frame_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,      // consume beat this cycle
    input  pcv_pkg::pcv_in_t   beat,
    input  pcv_pkg::pcv_cfg_t  cfg,
    output logic               emit,      // beat completes a frame
    output pcv_pkg::pcv_out_t  result
);

    pcv_pkg::pcv_phase_t phase_reg, phase_next;
    logic [15:0] header_sum_reg, header_sum_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;

    logic [14:0] term;
    logic [15:0] sum_add;
    logic [15:0] sum_new;

    // (b << 7) | b, then add and mask
    assign term    = {beat.data_byte, 7'd0} | {7'd0, beat.data_byte};
    assign sum_add = running_sum_reg + {1'b0, term} + cfg.add_offset;
    assign sum_new = sum_add ^ cfg.xor_mask;

    always_comb
    begin
        phase_next        = phase_reg;
        header_sum_next   = header_sum_reg;
        running_sum_next  = running_sum_reg;
        frame_length_next = frame_length_reg;
        bytes_left_next   = bytes_left_reg;
        emit              = 1'b0;

        if (beat.first_byte)
        begin
            header_sum_next = {8'd0, beat.data_byte};
            phase_next      = pcv_pkg::PH_HIGH;
        end
        else
        begin
            unique case (phase_reg)
                pcv_pkg::PH_IDLE: ;
                pcv_pkg::PH_HIGH:
                begin
                    header_sum_next = {beat.data_byte, header_sum_reg[7:0]};
                    phase_next      = pcv_pkg::PH_LEN;
                end
                pcv_pkg::PH_LEN:
                begin
                    frame_length_next = beat.data_byte;
                    bytes_left_next   = beat.data_byte;
                    running_sum_next  = 16'd0;
                    if (beat.data_byte == 8'd0)
                    begin
                        emit       = 1'b1;
                        phase_next = pcv_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = pcv_pkg::PH_DATA;
                    end
                end
                pcv_pkg::PH_DATA:
                begin
                    running_sum_next = sum_new;
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    if (bytes_left_reg == 8'd1)
                    begin
                        emit       = 1'b1;
                        phase_next = pcv_pkg::PH_IDLE;
                    end
                end
                default: phase_next = pcv_pkg::PH_IDLE;
            endcase
        end
    end

    assign result.sum_ok         = (running_sum_next == header_sum_next);
    assign result.payload_length = frame_length_next;
    assign result.computed_sum   = running_sum_next;
    assign result.stored_sum     = header_sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= pcv_pkg::PH_IDLE;
            header_sum_reg   <= 16'd0;
            running_sum_reg  <= 16'd0;
            frame_length_reg <= 8'd0;
            bytes_left_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            header_sum_reg   <= header_sum_next;
            running_sum_reg  <= running_sum_next;
            frame_length_reg <= frame_length_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

// File: design/packet_checksum_verifier_unit.sv
// Top level of the packet checksum verifier: byte input, result output, APB config.
`timescale 1ns / 1ps

// Verifies received radio frames fed one byte per beat. A frame is the
// stored checksum (low byte, then high byte), a length byte, then that many
// payload bytes; first_byte marks the checksum low byte and always restarts
// parsing, dropping any unfinished frame silently. Over the payload a 16-bit
// sum is kept: sum = ((sum + ((b << 7) | b) + add_offset) mod 2^16) ^ xor_mask.
// After the last payload byte, or right after a zero length byte (sum 0), one
// result beat carries the match flag, the length and both checksums. Bytes
// outside a frame produce nothing. Throughput is one byte per clock while
// results are taken: the beat is held in an input register, the parser does
// one add and one xor once the result slot is free or draining and loads the
// result register, which drives result_valid. A stalled result holds the
// input side only once the input register is also full.
// Config registers (APB, byte address 0: add_offset, 4: xor_mask) should be
// written only while no frame is in flight.
module packet_checksum_verifier_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          byte_valid,
    output logic                          byte_ready,
    input  pcv_pkg::pcv_in_t              byte_data,

    output logic                          result_valid,
    input  logic                          result_ready,
    output pcv_pkg::pcv_out_t             result_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcv_pkg::ADDR_W-1:0]    paddr,
    input  logic [pcv_pkg::DATA_W-1:0]    pwdata,
    output logic [pcv_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    pcv_pkg::pcv_cfg_t cfg;

    // input stage
    logic              in_valid_reg;
    pcv_pkg::pcv_in_t  in_data_reg;

    // result stage
    logic              out_valid_reg;
    pcv_pkg::pcv_out_t out_data_reg;

    logic              advance;
    logic              emit;
    pcv_pkg::pcv_out_t result;

    pcv_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Held beat moves on when the result slot is free or draining now.
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || advance;

    pcv_frame_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (in_data_reg),
        .cfg    (cfg),
        .emit   (emit),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_data_reg <= byte_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

// File: sim/pcv_frame_checker.sv
// Frame tracker and result scoreboard for the packet checksum verifier.
`timescale 1ns / 1ps

module pcv_frame_checker
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          byte_valid,
    input  logic                          byte_ready,
    input  pcv_pkg::pcv_in_t              byte_data,

    input  logic                          result_valid,
    input  logic                          result_ready,
    input  pcv_pkg::pcv_out_t             result_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [pcv_pkg::ADDR_W-1:0]    paddr,
    input  logic [pcv_pkg::DATA_W-1:0]    pwdata,

    output int                            fail_count,
    output int                            pending,
    output int                            beats_checked
);

    // Shadow of the frame parser
    pcv_pkg::pcv_phase_t frm_phase;
    logic [15:0] hdr_sum;
    logic [15:0] pay_sum;
    logic [7:0]  frm_len;
    logic [7:0]  bytes_left;
    logic [15:0] cfg_add;
    logic [15:0] cfg_xor;

    pcv_pkg::pcv_out_t verdict_q[$];
    pcv_pkg::pcv_out_t got_verdict;
    pcv_pkg::pcv_out_t want_verdict;
    int          fails;
    int          checked_n;

    task automatic post_verdict();
        pcv_pkg::pcv_out_t v;
        v.sum_ok         = (pay_sum == hdr_sum);
        v.payload_length = frm_len;
        v.computed_sum   = pay_sum;
        v.stored_sum     = hdr_sum;
        verdict_q.push_back(v);
        frm_phase = pcv_pkg::PH_IDLE;
    endtask

    task automatic absorb_byte(input pcv_pkg::pcv_in_t beat);
        logic [15:0] term;
        term = ({8'h00, beat.data_byte} << 7) | {8'h00, beat.data_byte};
        if (beat.first_byte)
        begin
            hdr_sum   = {8'h00, beat.data_byte};
            frm_phase = pcv_pkg::PH_HIGH;
        end
        else
        begin
            unique case (frm_phase)
                pcv_pkg::PH_HIGH:
                begin
                    hdr_sum[15:8] = beat.data_byte;
                    frm_phase     = pcv_pkg::PH_LEN;
                end
                pcv_pkg::PH_LEN:
                begin
                    frm_len    = beat.data_byte;
                    bytes_left = beat.data_byte;
                    pay_sum    = '0;
                    if (beat.data_byte == 8'd0)
                        post_verdict();
                    else
                        frm_phase = pcv_pkg::PH_DATA;
                end
                pcv_pkg::PH_DATA:
                begin
                    pay_sum    = (pay_sum + term + cfg_add) ^ cfg_xor;
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                        post_verdict();
                end
                default: ;  // idle: stray byte dropped
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frm_phase  = pcv_pkg::PH_IDLE;
            hdr_sum    = '0;
            pay_sum    = '0;
            frm_len    = '0;
            bytes_left = '0;
            cfg_add    = pcv_pkg::ADD_OFFSET_RESET;
            cfg_xor    = pcv_pkg::XOR_MASK_RESET;
            verdict_q.delete();
            fails      = 0;
            checked_n  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == pcv_pkg::REG_ADD_OFFSET)
                    cfg_add = pwdata[15:0];
                else
                    cfg_xor = pwdata[15:0];
            end

            // a result never belongs to a byte taken on the same edge
            if (result_valid && result_ready)
            begin
                got_verdict = result_data;
                if (verdict_q.size() == 0)
                begin
                    $error("result beat with no frame outstanding: 0x%0h", got_verdict);
                    fails++;
                end
                else
                begin
                    want_verdict = verdict_q.pop_front();
                    check_field("sum_ok", want_verdict.sum_ok, got_verdict.sum_ok);
                    check_field("payload_length", want_verdict.payload_length,
                                got_verdict.payload_length);
                    check_field("computed_sum", want_verdict.computed_sum,
                                got_verdict.computed_sum);
                    check_field("stored_sum", want_verdict.stored_sum,
                                got_verdict.stored_sum);
                    checked_n++;
                end
            end

            if (byte_valid && byte_ready)
                absorb_byte(byte_data);
        end
        fail_count    <= fails;
        pending       <= verdict_q.size();
        beats_checked <= checked_n;
    end

endmodule

// File: sim/tb.sv
// Top-level testbench for the packet checksum verifier: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;  // watchdog bound on the whole run
    localparam int PHASE_BYTES = 140;     // frame bytes per register setting
    localparam int HOLD_CYCLES = 300;     // long output stall
    localparam int NUM_PHASES  = 7;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;

    logic                 byte_valid   = 1'b0;
    logic                 byte_ready;
    pcv_pkg::pcv_in_t     byte_data    = '0;

    logic                 result_valid;
    logic                 result_ready = 1'b0;
    pcv_pkg::pcv_out_t    result_data;

    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [pcv_pkg::ADDR_W-1:0] paddr  = '0;
    logic [pcv_pkg::DATA_W-1:0] pwdata = '0;
    logic [pcv_pkg::DATA_W-1:0] prdata;
    logic                 pready;

    int                   fail_count;
    int                   pending;
    int                   beats_checked;

    // Register values as last programmed; used only to compute the expected
    // payload sum when building frames.
    logic [15:0]          cur_add      = pcv_pkg::ADD_OFFSET_RESET;
    logic [15:0]          cur_xor      = pcv_pkg::XOR_MASK_RESET;

    bit                   src_idle_on  = 1'b1;
    bit                   sink_idle_on = 1'b1;
    bit                   hold_req     = 1'b0;

    int                   bytes_sent   = 0;
    int                   frames_sent  = 0;
    int                   settings_used = 1;
    int                   cycles       = 0;

    packet_checksum_verifier_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    pcv_frame_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_data     (byte_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_data   (result_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("** packet_checksum_verifier_unit: FAILED **");
            $finish;
        end
    end

    // Result side. Normally ready with short random stalls; on request one
    // long stall so the input register and result register both fill and the
    // block has to push back on the byte stream.
    always
    begin
        @(posedge clk);
        if (hold_req)
        begin
            hold_req     <= 1'b0;
            result_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            result_ready <= 1'b1;
        end
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
        begin
            result_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            result_ready <= 1'b1;
        end
        else
            result_ready <= 1'b1;
    end

    // One input beat. Always entered right after a rising edge; valid stays
    // high into the next beat unless an idle burst is drawn.
    task automatic push_byte(input logic [7:0] b, input logic first);
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{data_byte: b, first_byte: first};
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
    endtask

    // Build and send one frame. match picks a correct stored checksum,
    // otherwise a near miss or a random value. truncate drops the frame at a
    // random point before its end; fill < 0 gives random payload bytes.
    task automatic send_frame(input int len, input bit match, input bit truncate,
                              input int fill);
        pcv_pkg::pcv_in_t beats[$];
        logic [7:0]  b;
        logic [15:0] sum;
        logic [15:0] stored;
        int          k;
        int          n;
        sum = '0;
        for (k = 0; k < len; k++)
        begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            beats.push_back('{data_byte: b, first_byte: 1'b0});
            sum = (sum + (({8'h00, b} << 7) | {8'h00, b}) + cur_add) ^ cur_xor;
        end
        if (match)
            stored = sum;
        else if ($urandom_range(0, 1) == 0)
            stored = sum ^ (16'h0001 << $urandom_range(0, 15));
        else
            stored = 16'($urandom);
        beats.push_front('{data_byte: 8'(len), first_byte: 1'b0});
        beats.push_front('{data_byte: stored[15:8], first_byte: 1'b0});
        beats.push_front('{data_byte: stored[7:0], first_byte: 1'b1});
        n = truncate ? $urandom_range(1, beats.size() - 1) : beats.size();
        for (k = 0; k < n; k++)
            push_byte(beats[k].data_byte, beats[k].first_byte);
        bytes_sent  += n;
        frames_sent += 1;
    endtask

    // Mostly short payloads; a few long ones and the odd full-length frame.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 6);
        else if (r < 97)
            return $urandom_range(7, 40);
        else if (r < 99)
            return $urandom_range(41, 254);
        else
            return 255;
    endfunction

    // Stop sending and wait for every expected result, then give the block
    // time to finish a byte that produces nothing (two-stage pipeline).
    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; pready is honored anyway.
    task automatic apb_write(input logic idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pcv_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= pcv_pkg::DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] add_val, input logic [15:0] xor_val);
        drain();
        apb_write(pcv_pkg::REG_ADD_OFFSET, add_val);
        apb_write(pcv_pkg::REG_XOR_MASK, xor_val);
        cur_add = add_val;
        cur_xor = xor_val;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int ph;
        int quota;
        int pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed beats, reset register values ----
        // stray bytes while idle are dropped
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        // zero length frame, stored 0: immediate match with sum 0
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        // byte after a result is ignored until the next frame start
        push_byte(8'h55, 1'b0);
        // zero length frame, stored 0xffff: mismatch
        push_byte(8'hff, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        // restart in the middle of the payload drops that frame
        push_byte(8'h12, 1'b1);
        push_byte(8'h34, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'hab, 1'b0);
        // two frame starts in a row: the second one wins
        push_byte(8'h77, 1'b1);
        // largest length byte, then cut off by a restart
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h01, 1'b0);
        // payload byte extremes, with matching checksums
        send_frame(1, 1'b1, 1'b0, 255);
        send_frame(2, 1'b1, 1'b0, 0);

        // ---- random phases, one register setting each ----
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            unique case (ph)
                1: program_regs(16'h0000, 16'h0000);
                2: program_regs(16'hffff, 16'hffff);
                3: program_regs(16'h0000, 16'hffff);
                4: program_regs(16'hffff, 16'h0000);
                5: program_regs(16'($urandom), 16'($urandom));
                6: program_regs(16'($urandom), 16'($urandom));
                default: ;  // first phase runs on reset values
            endcase

            quota = bytes_sent + PHASE_BYTES;

            if (ph == 1)
                send_frame(255, 1'b1, 1'b0, -1);

            if (ph == 2)
            begin
                // long output stall while zero length frames keep coming
                hold_req    <= 1'b1;
                src_idle_on  = 1'b0;
                repeat (40) send_frame(0, $urandom_range(0, 1), 1'b0, -1);
                src_idle_on  = 1'b1;
            end

            // final stretch runs back to back on both sides
            if (ph == NUM_PHASES - 1)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end

            while (bytes_sent < quota)
            begin
                if (ph == 3 && bytes_sent >= quota - PHASE_BYTES / 2 && pending != 0)
                    drain();  // mid-phase pause until the result side is empty
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_frame(pick_len(), $urandom_range(0, 2) != 0, 1'b0, -1);
                else if (pick < 85)
                    send_frame(pick_len(), 1'b1, 1'b1, -1);
                else if (pick < 95)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        push_byte(8'($urandom), 1'b0);
                        bytes_sent++;
                    end
                end
                else
                begin
                    // raw noise, frame starts included
                    repeat ($urandom_range(1, 6))
                    begin
                        push_byte(8'($urandom), $urandom_range(0, 3) == 0);
                        bytes_sent++;
                    end
                end
            end

            // leave the parser idle before the next register write
            send_frame(pick_len() % 8, 1'b1, 1'b0, -1);
        end

        drain();
        repeat (6) @(posedge clk);

        $display("Sent %0d frame bytes in %0d frames under %0d register settings;",
                 bytes_sent, frames_sent, settings_used);
        $display("%0d results checked. Zero and full length, restarts, truncation,",
                 beats_checked);
        $display("stray bytes and a %0d-cycle stall.", HOLD_CYCLES);
        if (fail_count == 0)
            $display("** packet_checksum_verifier_unit: PASSED **");
        else
            $display("** packet_checksum_verifier_unit: FAILED **");
        $finish;
    end

endmodule
